// ===== sv/tcw_pkg.sv =====
// tcw_pkg: shared types and constants for the text console writer
// command and status structs between controller and datapath, item codes
// no dependencies
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int KIND_W  = 2;
    localparam int CODE_W  = 8;
    localparam int IDX_W   = 11;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

    localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_RETURN    = 8'd13;
    localparam logic [CODE_W-1:0] CHAR_SPACE     = 8'h20;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
    localparam logic [CELL_W-1:0]  BLANK_RESET = {BG_RESET, FG_RESET, CHAR_SPACE};

    typedef enum logic [2:0] {
        PUT_NONE,
        PUT_PRINT,
        PUT_NEWLINE,
        PUT_RETURN,
        PUT_BACK
    } put_class_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        WR_RESET_BLANK,
        WR_BLANK,
        WR_CHAR,
        WR_COPY
    } wr_sel_t;

    typedef enum logic [1:0] {
        ADDR_PTR,
        ADDR_CURSOR,
        ADDR_CURSOR_BACK
    } addr_sel_t;

    typedef enum logic {
        RD_NEXT_ROW,
        RD_INDEX
    } rd_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_RETURN,
        CUR_BACK,
        CUR_UP
    } cur_op_t;

    typedef struct packed {
        logic      load_item;
        ptr_op_t   ptr_op;
        logic      mem_wr;
        wr_sel_t   wr_sel;
        addr_sel_t addr_sel;
        logic      mem_rd;
        rd_sel_t   rd_sel;
        cur_op_t   cur_op;
    } cmd_t;

    typedef struct packed {
        put_class_t put_class;
        logic       col_zero;
        logic       line_full;
        logic       ptr_end_copy;
        logic       ptr_end_all;
    } stat_t;

endpackage

// ===== sv/tcw_ctrl.sv =====
// tcw_ctrl: sequencer for the text console writer
// steps put, clear, read, scroll and reset clearing through the datapath
// depends on tcw_pkg
module tcw_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tcw_pkg::KIND_W-1:0]    kind,
    input  tcw_pkg::stat_t                stat,
    output tcw_pkg::cmd_t                 cmd,
    output logic                          busy,
    output logic                          done
);
    import tcw_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_CHECK,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL_ROW,
        S_CLEAR,
        S_READ,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '{load_item: 1'b0, ptr_op: PTR_HOLD, mem_wr: 1'b0, wr_sel: WR_BLANK,
                       addr_sel: ADDR_PTR, mem_rd: 1'b0, rd_sel: RD_NEXT_ROW,
                       cur_op: CUR_HOLD};
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_sel = WR_RESET_BLANK;
                cmd.ptr_op = PTR_INC;
                if (stat.ptr_end_all)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.ptr_op = PTR_ZERO;
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    case (kind)
                        KIND_PUT:   state_next = S_PUT;
                        KIND_CLEAR: state_next = S_CLEAR;
                        KIND_READ:  state_next = S_READ;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_PUT:
            begin
                case (stat.put_class)
                    PUT_PRINT:
                    begin
                        cmd.mem_wr   = 1'b1;
                        cmd.wr_sel   = WR_CHAR;
                        cmd.addr_sel = ADDR_CURSOR;
                        cmd.cur_op   = CUR_ADVANCE;
                    end
                    PUT_NEWLINE: cmd.cur_op = CUR_NEWLINE;
                    PUT_RETURN:  cmd.cur_op = CUR_RETURN;
                    PUT_BACK:
                    begin
                        if (!stat.col_zero)
                        begin
                            cmd.mem_wr   = 1'b1;
                            cmd.wr_sel   = WR_BLANK;
                            cmd.addr_sel = ADDR_CURSOR_BACK;
                            cmd.cur_op   = CUR_BACK;
                        end
                    end
                    default: cmd.cur_op = CUR_HOLD;
                endcase
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.ptr_op = PTR_ZERO;
                state_next = stat.line_full ? S_SCR_RD : S_DONE;
            end
            S_SCR_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = RD_NEXT_ROW;
                state_next = S_SCR_WR;
            end
            S_SCR_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_sel = WR_COPY;
                cmd.ptr_op = PTR_INC;
                state_next = stat.ptr_end_copy ? S_FILL_ROW : S_SCR_RD;
            end
            S_FILL_ROW:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_sel = WR_BLANK;
                cmd.ptr_op = PTR_INC;
                if (stat.ptr_end_all)
                begin
                    cmd.cur_op = CUR_UP;
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_sel = WR_BLANK;
                cmd.ptr_op = PTR_INC;
                if (stat.ptr_end_all)
                begin
                    cmd.cur_op = CUR_HOME;
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = RD_INDEX;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ===== sv/tcw_datapath.sv =====
// tcw_datapath: screen store, cursor, color registers and item latch
// executes controller commands and reports status
// depends on tcw_pkg
module tcw_datapath
#(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcw_pkg::cmd_t                    cmd,
    output tcw_pkg::stat_t                   stat,
    input  logic [tcw_pkg::KIND_W-1:0]       kind,
    input  logic [tcw_pkg::CODE_W-1:0]       char_code,
    input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
    input  logic                             cfg_write,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data,
    output logic [tcw_pkg::POS_W-1:0]        cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]       cell_value
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int LINE_W     = $clog2(ROWS + 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COLUMNS * (ROWS - 1) - 1);
    localparam logic [ADDR_W-1:0] ALL_LAST  = ADDR_W'(CELL_COUNT - 1);

    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic [KIND_W-1:0]  kind_reg;
    logic [CODE_W-1:0]  char_reg;
    logic [ADDR_W-1:0]  index_reg;
    logic               index_ok_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [LINE_W-1:0]  line_reg;
    logic [LINE_W-1:0]  line_next;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [ADDR_W-1:0]  ptr_reg;
    logic [ADDR_W-1:0]  ptr_next;
    logic [CELL_W-1:0]  rd_data_reg;

    logic [ADDR_W-1:0]  cursor_idx;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CELL_W-1:0]  wr_data;
    logic [CELL_W-1:0]  blank;

    assign cursor_idx = ADDR_W'(int'(line_reg) * COLUMNS + int'(col_reg));
    assign blank      = {bg_reg, fg_reg, CHAR_SPACE};

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg     <= kind;
            char_reg     <= char_code;
            index_reg    <= ADDR_W'(cell_index);
            index_ok_reg <= (int'(cell_index) < CELL_COUNT);
        end
    end

    // color registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FOREGROUND: fg_reg <= cfg_data;
                CFG_BACKGROUND: bg_reg <= cfg_data;
                default:        fg_reg <= fg_reg;
            endcase
        end
    end

    // cursor update
    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        case (cmd.cur_op)
            CUR_HOME:
            begin
                col_next  = '0;
                line_next = '0;
            end
            CUR_ADVANCE:
            begin
                if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    col_next  = '0;
                    line_next = line_reg + LINE_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            CUR_NEWLINE:
            begin
                col_next  = '0;
                line_next = line_reg + LINE_W'(1);
            end
            CUR_RETURN: col_next  = '0;
            CUR_BACK:   col_next  = col_reg - COL_W'(1);
            CUR_UP:     line_next = line_reg - LINE_W'(1);
            default:    col_next  = col_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.ptr_op)
            PTR_ZERO: ptr_next = '0;
            PTR_INC:  ptr_next = ptr_reg + ADDR_W'(1);
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
            ptr_reg  <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
            ptr_reg  <= ptr_next;
        end
    end

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_CURSOR:      wr_addr = cursor_idx;
            ADDR_CURSOR_BACK: wr_addr = cursor_idx - ADDR_W'(1);
            default:          wr_addr = ptr_reg;
        endcase
        case (cmd.wr_sel)
            WR_RESET_BLANK: wr_data = BLANK_RESET;
            WR_CHAR:        wr_data = {bg_reg, fg_reg, char_reg};
            WR_COPY:        wr_data = rd_data_reg;
            default:        wr_data = blank;
        endcase
        case (cmd.rd_sel)
            RD_INDEX: rd_addr = index_reg;
            default:  rd_addr = ADDR_W'(int'(ptr_reg) + COLUMNS);
        endcase
    end

    // screen store
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        if (char_reg == CHAR_NEWLINE)
        begin
            stat.put_class = PUT_NEWLINE;
        end
        else if (char_reg == CHAR_RETURN)
        begin
            stat.put_class = PUT_RETURN;
        end
        else if (char_reg == CHAR_BACKSPACE)
        begin
            stat.put_class = PUT_BACK;
        end
        else if (!char_reg[7] && (char_reg[6:5] != 2'b00))
        begin
            stat.put_class = PUT_PRINT;
        end
        else
        begin
            stat.put_class = PUT_NONE;
        end
        stat.col_zero     = (col_reg == '0);
        stat.line_full    = (line_reg == LINE_W'(ROWS));
        stat.ptr_end_copy = (ptr_reg == COPY_LAST);
        stat.ptr_end_all  = (ptr_reg == ALL_LAST);
    end

    assign cursor_position = POS_W'(cursor_idx);
    assign cell_value      = ((kind_reg == KIND_READ) && index_ok_reg) ? rd_data_reg : '0;

endmodule

// ===== sv/text_console_writer_unit.sv =====
// text_console_writer_unit: top level of the text console writer
// joins tcw_ctrl and tcw_datapath
// depends on tcw_pkg, tcw_ctrl, tcw_datapath
//
// channel   direction  handshake                 payload
// item      in         start & !busy             kind, char_code, cell_index
// result    out        done, one cycle           cursor_position, cell_value
// config    in         cfg_write                 cfg_index, cfg_data
//
// from accept until the next item can be taken: a put steps through the put and check states,
// a read through the read state, kind 3 straight to done; a put that scrolls then reads and
// writes each moved cell in turn, set by the single store port pair, and blanks the last row
// clear blanks every cell, one cell written per cycle
// after reset busy stays high while the store is blanked
// the result cannot be held off; done is high for one cycle
module text_console_writer_unit
#(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tcw_pkg::KIND_W-1:0]       kind,
    input  logic [tcw_pkg::CODE_W-1:0]       char_code,
    input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
    output logic                             done,
    output logic [tcw_pkg::POS_W-1:0]        cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]       cell_value,
    input  logic                             cfg_write,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data
);
    import tcw_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tcw_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    tcw_datapath
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .kind            (kind),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cursor_position (cursor_position),
        .cell_value      (cell_value)
    );

endmodule
